### design/range_window_obstacle_vote_unit_assert.svh
// Assertion macros shared by the obstacle vote unit RTL.
`ifndef RANGE_WINDOW_OBSTACLE_VOTE_UNIT_ASSERT_SVH
`define RANGE_WINDOW_OBSTACLE_VOTE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define RWOV_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define RWOV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define RWOV_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define RWOV_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### design/rwov_pkg.sv
// Shared widths, register codes and reset values of the obstacle vote unit.
`default_nettype none

package rwov_pkg;

   localparam int RANGE_W    = 16;
   localparam int VOTE_W     = 9;
   localparam int WIN_W      = 5;
   localparam int ANGLE_W    = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int VOTE_SHIFT = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_DISTANCE      = 3'd0,
      CSR_MAX_DISTANCE      = 3'd1,
      CSR_CRITICAL_DISTANCE = 3'd2,
      CSR_VOTE_THRESHOLD    = 3'd3,
      CSR_WINDOW_IN_USE     = 3'd4
   } csr_index_type;

   localparam logic [RANGE_W-1:0] MIN_DISTANCE_RST      = 16'd0;
   localparam logic [RANGE_W-1:0] MAX_DISTANCE_RST      = 16'd1500;
   localparam logic [RANGE_W-1:0] CRITICAL_DISTANCE_RST = 16'd1500;
   localparam logic [VOTE_W-1:0]  VOTE_THRESHOLD_RST    = 9'd128;
   localparam logic [WIN_W-1:0]   WINDOW_IN_USE_RST     = 5'd1;

endpackage

`default_nettype wire

### design/rwov_if.sv
// Request and response channel interfaces of the obstacle vote unit.
`default_nettype none

interface rwov_req_if;
   logic                            valid;
   logic                            ready;
   logic [rwov_pkg::RANGE_W-1:0]    reading_range;
   logic [rwov_pkg::RANGE_W-1:0]    sensor_min_range;
   logic [rwov_pkg::RANGE_W-1:0]    sensor_max_range;
   logic [rwov_pkg::ANGLE_W-1:0]    view_angle;

   modport source (
      output valid, reading_range, sensor_min_range, sensor_max_range, view_angle,
      input  ready
   );
   modport sink (
      input  valid, reading_range, sensor_min_range, sensor_max_range, view_angle,
      output ready
   );
endinterface

interface rwov_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            obstacle_present;
   logic [rwov_pkg::RANGE_W-1:0]    obstacle_range;
   logic [rwov_pkg::RANGE_W-1:0]    danger_level;
   logic [rwov_pkg::ANGLE_W-1:0]    latest_view_angle;

   modport source (
      output valid, obstacle_present, obstacle_range, danger_level, latest_view_angle,
      input  ready
   );
   modport sink (
      input  valid, obstacle_present, obstacle_range, danger_level, latest_view_angle,
      output ready
   );
endinterface

`default_nettype wire

### design/rwov_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rwov_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [ADDR_W-1:0]       wr_addr,
   input  wire logic [WIDTH-1:0]        wr_data,
   input  wire logic                    rd_en,
   input  wire logic [ADDR_W-1:0]       rd_addr,
   output      logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/rwov_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module rwov_div #(
   parameter int DIVIDEND_W = 21,
   parameter int DIVISOR_W  = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [DIVIDEND_W-1:0]   dividend,
   input  wire logic [DIVISOR_W-1:0]    divisor,
   output      logic                    done,
   output      logic [DIVIDEND_W-1:0]   quotient
);

   localparam int CNT_BITS = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // Shift in the next dividend bit and try to subtract.
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### design/range_window_obstacle_vote_unit.sv
// A request passes through the write-slot wrap steps, the window walk, a drain, the vote,
// the decision and, with an obstacle, the divider before the response is staged. One
// request at a time: the next can be taken in the cycle after the response is loaded.
// Reset: synchronous, active high; all ring slots read as no reading at once through
// per-slot valid flops, write slot 0, registers at their documented reset values.
`default_nettype none

`include "range_window_obstacle_vote_unit_assert.svh"

module range_window_obstacle_vote_unit #(
   parameter int WINDOW = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rwov_req_if.sink                                 req_ch,
   rwov_rsp_if.source                               rsp_ch,
   input  wire logic                                csr_wr_en,
   input  wire logic [rwov_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rwov_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int RANGE_W = rwov_pkg::RANGE_W;
   localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int NW      = (CNT_W > rwov_pkg::WIN_W) ? CNT_W : rwov_pkg::WIN_W;
   localparam int SUM_W   = RANGE_W + CNT_W;
   localparam int PROD_W  = rwov_pkg::VOTE_W + CNT_W;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [RANGE_W-1:0]             min_distance_ff, min_distance_in;
   logic [RANGE_W-1:0]             max_distance_ff, max_distance_in;
   logic [RANGE_W-1:0]             critical_distance_ff, critical_distance_in;
   logic [rwov_pkg::VOTE_W-1:0]    vote_threshold_ff, vote_threshold_in;
   logic [rwov_pkg::WIN_W-1:0]     window_in_use_ff, window_in_use_in;

   always_comb begin
      min_distance_in      = min_distance_ff;
      max_distance_in      = max_distance_ff;
      critical_distance_in = critical_distance_ff;
      vote_threshold_in    = vote_threshold_ff;
      window_in_use_in     = window_in_use_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rwov_pkg::CSR_MIN_DISTANCE:      min_distance_in      = csr_wr_data;
            rwov_pkg::CSR_MAX_DISTANCE:      max_distance_in      = csr_wr_data;
            rwov_pkg::CSR_CRITICAL_DISTANCE: critical_distance_in = csr_wr_data;
            rwov_pkg::CSR_VOTE_THRESHOLD: begin
               vote_threshold_in = csr_wr_data[rwov_pkg::VOTE_W-1:0];
            end
            rwov_pkg::CSR_WINDOW_IN_USE: begin
               window_in_use_in = csr_wr_data[rwov_pkg::WIN_W-1:0];
            end
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_distance_ff      <= rwov_pkg::MIN_DISTANCE_RST;
         max_distance_ff      <= rwov_pkg::MAX_DISTANCE_RST;
         critical_distance_ff <= rwov_pkg::CRITICAL_DISTANCE_RST;
         vote_threshold_ff    <= rwov_pkg::VOTE_THRESHOLD_RST;
         window_in_use_ff     <= rwov_pkg::WINDOW_IN_USE_RST;
      end else begin
         min_distance_ff      <= min_distance_in;
         max_distance_ff      <= max_distance_in;
         critical_distance_ff <= critical_distance_in;
         vote_threshold_ff    <= vote_threshold_in;
         window_in_use_ff     <= window_in_use_in;
      end
   end

   // Clamp the window: zero acts as one, anything above WINDOW as WINDOW.
   logic [NW-1:0]    win_ext;
   logic [CNT_W-1:0] win_n;

   assign win_ext = NW'(window_in_use_ff);

   always_comb begin
      if (win_ext == '0) begin
         win_n = CNT_W'(1);
      end else if (win_ext > NW'(WINDOW)) begin
         win_n = CNT_W'(WINDOW);
      end else begin
         win_n = CNT_W'(win_ext);
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_WALK,
      ST_DRAIN,
      ST_VOTE,
      ST_DECIDE,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type                     state_ff, state_in;
   logic [IDX_W-1:0]              ws_ff, ws_in;
   logic [CNT_W-1:0]              slot_ff, slot_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic                          acc_en_ff, acc_en_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic [CNT_W-1:0]              hits_ff, hits_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [WINDOW-1:0]             valid_ff, valid_in;

   // Request held for the duration of the walk.
   logic [RANGE_W-1:0]            rng_ff, rng_in;
   logic                          span_ff, span_in;
   logic [rwov_pkg::ANGLE_W-1:0]  fov_ff, fov_in;

   // Result staged before the response register.
   logic                          res_present_ff, res_present_in;
   logic [RANGE_W-1:0]            res_range_ff, res_range_in;
   logic [RANGE_W-1:0]            res_danger_ff, res_danger_in;

   // Response register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_present_ff, rsp_present_in;
   logic [RANGE_W-1:0]            rsp_range_ff, rsp_range_in;
   logic [RANGE_W-1:0]            rsp_danger_ff, rsp_danger_in;
   logic [rwov_pkg::ANGLE_W-1:0]  rsp_angle_ff, rsp_angle_in;

   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic [RANGE_W-1:0]            ram_rd_data;
   logic                          hit;
   logic                          div_start;
   logic                          div_done;
   logic [SUM_W-1:0]              div_quo;
   logic [RANGE_W-1:0]            mean;

   assign req_ch.ready = (state_ff == ST_IDLE);

   // A hit is a stored, in-span reading strictly inside the distance band.
   assign hit = acc_en_ff && rd_valid_ff &&
                (ram_rd_data > min_distance_ff) && (ram_rd_data < max_distance_ff);

   assign mean = div_quo[RANGE_W-1:0];

   always_comb begin
      state_in       = state_ff;
      ws_in          = ws_ff;
      slot_in        = slot_ff;
      idx_in         = idx_ff;
      acc_en_in      = 1'b0;
      rd_valid_in    = valid_ff[idx_ff];
      hits_in        = hits_ff;
      sum_in         = sum_ff;
      prod_in        = prod_ff;
      valid_in       = valid_ff;
      rng_in         = rng_ff;
      span_in        = span_ff;
      fov_in         = fov_ff;
      res_present_in = res_present_ff;
      res_range_in   = res_range_ff;
      res_danger_in  = res_danger_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_present_in = rsp_present_ff;
      rsp_range_in   = rsp_range_ff;
      rsp_danger_in  = rsp_danger_ff;
      rsp_angle_in   = rsp_angle_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      div_start      = 1'b0;

      // Drop the response once the consumer takes it.
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Accumulate the entry read in the previous cycle.
      if (hit) begin
         hits_in = hits_ff + CNT_W'(1);
         sum_in  = sum_ff + SUM_W'(ram_rd_data);
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Take a request; a reading outside its own sensor span is stored
            // as no reading.
            if (req_ch.valid) begin
               rng_in   = req_ch.reading_range;
               span_in  = (req_ch.sensor_min_range < req_ch.reading_range) &&
                          (req_ch.reading_range < req_ch.sensor_max_range);
               fov_in   = req_ch.view_angle;
               slot_in  = CNT_W'(ws_ff) + CNT_W'(1);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // Wrap the slot into the window, then write the reading there.
            if (slot_ff >= win_n) begin
               slot_in = slot_ff - win_n;
            end else begin
               ram_wr_en                      = 1'b1;
               valid_in[slot_ff[IDX_W-1:0]]   = span_ff;
               ws_in                          = slot_ff[IDX_W-1:0];
               idx_in                         = '0;
               hits_in                        = '0;
               sum_in                         = '0;
               state_in                       = ST_WALK;
            end
         end
         ST_WALK: begin
            // Read one slot per cycle; the data returns next cycle.
            ram_rd_en = 1'b1;
            acc_en_in = 1'b1;
            if (CNT_W'(idx_ff) == (win_n - CNT_W'(1))) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_VOTE;
         end
         ST_VOTE: begin
            prod_in  = PROD_W'(vote_threshold_ff) * PROD_W'(win_n);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // Obstacle when hits * 256 >= threshold * window and at least one hit.
            if ((hits_ff != '0) &&
                ((PROD_W'(hits_ff) << rwov_pkg::VOTE_SHIFT) >= prod_ff)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               res_present_in = 1'b0;
               res_range_in   = '0;
               res_danger_in  = '0;
               state_in       = ST_OUT;
            end
         end
         ST_DIV: begin
            // Hold until the mean comes back from the divider.
            if (div_done) begin
               res_present_in = 1'b1;
               res_range_in   = mean;
               res_danger_in  = (mean < critical_distance_ff) ?
                                (critical_distance_ff - mean) : '0;
               state_in       = ST_OUT;
            end
         end
         ST_OUT: begin
            // Advance into the response register once it is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_present_in = res_present_ff;
               rsp_range_in   = res_range_ff;
               rsp_danger_in  = res_danger_ff;
               rsp_angle_in   = fov_ff;
               state_in       = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ws_ff        <= '0;
         acc_en_ff    <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         acc_en_ff    <= acc_en_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff        <= slot_in;
      idx_ff         <= idx_in;
      rd_valid_ff    <= rd_valid_in;
      hits_ff        <= hits_in;
      sum_ff         <= sum_in;
      prod_ff        <= prod_in;
      rng_ff         <= rng_in;
      span_ff        <= span_in;
      fov_ff         <= fov_in;
      res_present_ff <= res_present_in;
      res_range_ff   <= res_range_in;
      res_danger_ff  <= res_danger_in;
      rsp_present_ff <= rsp_present_in;
      rsp_range_ff   <= rsp_range_in;
      rsp_danger_ff  <= rsp_danger_in;
      rsp_angle_ff   <= rsp_angle_in;
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.obstacle_present  = rsp_present_ff;
   assign rsp_ch.obstacle_range    = rsp_range_ff;
   assign rsp_ch.danger_level      = rsp_danger_ff;
   assign rsp_ch.latest_view_angle = rsp_angle_ff;

   // ------------------------------------------------------------------
   // Reading ring and mean divider
   // ------------------------------------------------------------------
   rwov_ram #(
      .WIDTH (RANGE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff[IDX_W-1:0]),
      .wr_data (rng_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   rwov_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (hits_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `RWOV_ASSERT_IMPLY(a_div_nonzero, clock, reset, div_start, hits_ff != '0, "divide with zero hits")
   `RWOV_ASSERT_IMPLY(a_mean_fits, clock, reset, (state_ff == ST_DIV) && div_done, div_quo[SUM_W-1:RANGE_W] == '0, "mean exceeds range width")
   `RWOV_ASSERT_IMPLY(a_clear_absent, clock, reset, rsp_valid_ff && !rsp_present_ff, (rsp_range_ff == '0) && (rsp_danger_ff == '0), "no-obstacle response not cleared")
   `RWOV_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "request taken while busy")

endmodule

`default_nettype wire

### test/range_window_obstacle_vote_unit_tb.sv
// Self-checking testbench for the windowed range obstacle vote unit.
`timescale 1ns / 1ps

module range_window_obstacle_vote_unit_tb;

   localparam int RANGE_W     = rwov_pkg::RANGE_W;
   localparam int ANGLE_W     = rwov_pkg::ANGLE_W;
   localparam int RING_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASES      = 12;

   // One sensor reading as offered on the request channel.
   typedef struct packed {
      logic [RANGE_W-1:0] reading_range;
      logic [RANGE_W-1:0] sensor_min_range;
      logic [RANGE_W-1:0] sensor_max_range;
      logic [ANGLE_W-1:0] view_angle;
   } reading_type;

   // One vote outcome as seen on the response channel.
   typedef struct packed {
      logic               obstacle_present;
      logic [RANGE_W-1:0] obstacle_range;
      logic [RANGE_W-1:0] danger_level;
      logic [ANGLE_W-1:0] latest_view_angle;
   } obstacle_vote_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_wr_en;
   logic [rwov_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rwov_pkg::CSR_DATA_W-1:0] csr_wr_data;

   rwov_req_if req_bus ();
   rwov_rsp_if rsp_bus ();

   range_window_obstacle_vote_unit #(
      .WINDOW(RING_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor copy of the register file.
   logic [RANGE_W-1:0]          band_min_mm;
   logic [RANGE_W-1:0]          band_max_mm;
   logic [RANGE_W-1:0]          critical_mm;
   logic [rwov_pkg::VOTE_W-1:0] vote_fraction;
   logic [rwov_pkg::WIN_W-1:0]  window_setting;

   // Predictor copy of the reading ring: bit 16 flags a stored reading.
   logic [RANGE_W:0]   ring_model [RING_DEPTH];
   logic [3:0]         last_slot;

   reading_type       pending_readings [$];
   obstacle_vote_type expected_votes [$];

   int unsigned readings_queued;
   int unsigned votes_seen;
   int unsigned failures;
   int unsigned cycle_count;

   // Pacing: when clear, the sender never pauses and the receiver stalls only in a hold-off.
   bit          pace_bursty;
   int unsigned gap_left;
   int unsigned burst_left;
   int unsigned hold_left;
   logic [15:0] stall_pattern;
   int unsigned pattern_step;
   logic        offer_next;
   logic        ready_next;
   reading_type next_reading;
   obstacle_vote_type want;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // Store the reading, walk the window and vote, just as the block does.
   function automatic obstacle_vote_type predict_vote(input reading_type rd);
      int unsigned    n;
      int unsigned    slot;
      int unsigned    hits;
      int unsigned    hit_sum;
      int unsigned    i;
      logic [RANGE_W-1:0] r;
      obstacle_vote_type res;
      n = (window_setting == 0) ? 1 :
          ((window_setting > RING_DEPTH) ? RING_DEPTH : window_setting);
      slot = (last_slot + 1) % n;
      last_slot = 4'(slot);
      // A reading outside its own sensor span is kept as no reading.
      if (rd.sensor_min_range < rd.reading_range && rd.reading_range < rd.sensor_max_range)
         ring_model[slot] = {1'b1, rd.reading_range};
      else
         ring_model[slot] = '0;
      hits = 0;
      hit_sum = 0;
      for (i = 0; i < n; i++) begin
         r = ring_model[i][RANGE_W-1:0];
         if (ring_model[i][RANGE_W] && band_min_mm < r && r < band_max_mm) begin
            hits++;
            hit_sum += r;
         end
      end
      res = '0;
      res.latest_view_angle = rd.view_angle;
      // Zero hits never vote an obstacle, even with a zero fraction.
      if (hits > 0 && hits * 256 >= vote_fraction * n) begin
         res.obstacle_present = 1'b1;
         res.obstacle_range = RANGE_W'(hit_sum / hits);
         if (res.obstacle_range < critical_mm)
            res.danger_level = critical_mm - res.obstacle_range;
      end
      return res;
   endfunction

   function automatic reading_type reading(input int unsigned r, input int unsigned lo,
                                           input int unsigned hi, input int unsigned ang);
      reading_type rd;
      rd.reading_range    = RANGE_W'(r);
      rd.sensor_min_range = RANGE_W'(lo);
      rd.sensor_max_range = RANGE_W'(hi);
      rd.view_angle       = ANGLE_W'(ang);
      return rd;
   endfunction

   // Mostly valid readings inside the distance band, so votes build up in the
   // window; the rest are valid readings anywhere, rejected readings and noise.
   function automatic reading_type random_reading();
      int unsigned kind;
      int unsigned mn;
      int unsigned mx;
      int unsigned lo;
      int unsigned hi;
      int unsigned r;
      reading_type rd;
      kind = $urandom_range(9, 0);
      mn = band_min_mm;
      mx = band_max_mm;
      rd.view_angle = ANGLE_W'($urandom);
      if (kind == 9) begin
         rd.reading_range    = RANGE_W'($urandom);
         rd.sensor_min_range = RANGE_W'($urandom);
         rd.sensor_max_range = RANGE_W'($urandom);
      end else begin
         if (kind <= 5 && mx > mn + 1) begin
            lo = mn + 1;
            hi = mx - 1;
         end else begin
            lo = 1;
            hi = 65534;
         end
         r = $urandom_range(hi, lo);
         rd.reading_range = RANGE_W'(r);
         if (kind <= 7) begin
            rd.sensor_min_range = RANGE_W'($urandom_range(r - 1, 0));
            rd.sensor_max_range = RANGE_W'($urandom_range(65535, r + 1));
         end else if ($urandom_range(1, 0) == 0) begin
            rd.sensor_min_range = RANGE_W'($urandom_range(65535, r));
            rd.sensor_max_range = RANGE_W'($urandom);
         end else begin
            rd.sensor_min_range = RANGE_W'($urandom);
            rd.sensor_max_range = RANGE_W'($urandom_range(r, 0));
         end
      end
      return rd;
   endfunction

   task automatic queue_reading(input reading_type rd);
      pending_readings = {pending_readings, rd};
      readings_queued++;
   endtask

   task automatic write_reg(input rwov_pkg::csr_index_type idx,
                            input logic [rwov_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
   endtask

   // Write every register back to back and mirror them in the predictor.
   task automatic apply_config(input logic [15:0] mn, input logic [15:0] mx,
                               input logic [15:0] crit, input logic [8:0] frac,
                               input logic [4:0] win);
      write_reg(rwov_pkg::CSR_MIN_DISTANCE, mn);
      write_reg(rwov_pkg::CSR_MAX_DISTANCE, mx);
      write_reg(rwov_pkg::CSR_CRITICAL_DISTANCE, crit);
      write_reg(rwov_pkg::CSR_VOTE_THRESHOLD, rwov_pkg::CSR_DATA_W'(frac));
      write_reg(rwov_pkg::CSR_WINDOW_IN_USE, rwov_pkg::CSR_DATA_W'(win));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      band_min_mm    = mn;
      band_max_mm    = mx;
      critical_mm    = crit;
      vote_fraction  = frac;
      window_setting = win;
   endtask

   // Hold until every queued request has its response, then settle a little.
   task automatic wait_idle();
      while (votes_seen < readings_queued)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Stimulus: reset, directed cases, then phases of random readings under
   // different register settings.
   initial begin
      int unsigned ph;
      int unsigned k;
      int unsigned count;
      int unsigned mn;
      reset                    = 1'b1;
      csr_wr_en                = 1'b0;
      csr_index                = '0;
      csr_wr_data              = '0;
      req_bus.valid            = 1'b0;
      req_bus.reading_range    = '0;
      req_bus.sensor_min_range = '0;
      req_bus.sensor_max_range = '0;
      req_bus.view_angle       = '0;
      rsp_bus.ready            = 1'b0;
      readings_queued = 0;
      votes_seen      = 0;
      failures        = 0;
      cycle_count     = 0;
      pace_bursty     = 1'b0;
      gap_left        = 0;
      burst_left      = 0;
      hold_left       = 0;
      pattern_step    = 0;
      stall_pattern   = 16'hffff;
      band_min_mm     = rwov_pkg::MIN_DISTANCE_RST;
      band_max_mm     = rwov_pkg::MAX_DISTANCE_RST;
      critical_mm     = rwov_pkg::CRITICAL_DISTANCE_RST;
      vote_fraction   = rwov_pkg::VOTE_THRESHOLD_RST;
      window_setting  = rwov_pkg::WINDOW_IN_USE_RST;
      last_slot       = '0;
      for (k = 0; k < RING_DEPTH; k++)
         ring_model[k] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: window of one, band (0, 1500), half vote.
      queue_reading(reading(0, 0, 65535, 0));              // range at sensor minimum
      queue_reading(reading(65535, 0, 65535, 8191));       // range at sensor maximum
      queue_reading(reading(1, 0, 2, 8191));               // smallest hit
      queue_reading(reading(1499, 0, 65535, 6283));        // top of the band
      queue_reading(reading(1500, 0, 65535, 1));           // band is exclusive
      queue_reading(reading(700, 700, 65535, 4096));
      queue_reading(reading(700, 0, 700, 2048));
      queue_reading(reading(800, 799, 801, 100));
      queue_reading(reading(65535, 65535, 65535, 8191));
      queue_reading(reading(500, 1000, 200, 3000));        // inverted sensor span
      wait_idle();

      // Zero fraction with zero hits, then hits at the extremes.
      apply_config(16'd0, 16'd65535, 16'd65535, 9'd0, 5'd4);
      queue_reading(reading(0, 0, 0, 0));
      queue_reading(reading(300, 400, 65535, 10));
      queue_reading(reading(300, 0, 300, 20));
      queue_reading(reading(65535, 0, 65535, 30));
      queue_reading(reading(65534, 0, 65535, 40));
      queue_reading(reading(1, 0, 65535, 50));
      queue_reading(reading(32768, 32767, 32769, 5461));
      wait_idle();

      // Inverted band, unreachable fraction, window zero.
      apply_config(16'd100, 16'd50, 16'd0, 9'd511, 5'd0);
      queue_reading(reading(75, 0, 65535, 1234));
      queue_reading(reading(75, 0, 65535, 4321));
      queue_reading(reading(20, 0, 65535, 7000));
      wait_idle();

      for (ph = 0; ph < PHASES; ph++) begin
         unique case (ph)
            0:       apply_config(16'd100, 16'd2000, 16'd1500, 9'd128, 5'd16);
            1:       apply_config(16'd100, 16'd2000, 16'd1500, 9'd200, 5'd5);   // shrink window
            2:       apply_config(16'd0, 16'd65535, 16'd65535, 9'd1, 5'd31);    // oversized window
            3:       apply_config(16'd0, 16'd1500, 16'd1500, 9'd0, 5'd0);
            4:       apply_config(16'd65535, 16'd0, 16'd0, 9'd256, 5'd16);
            5:       apply_config(16'd3000, 16'd1000, 16'd2000, 9'd128, 5'd8);  // empty band
            6:       apply_config(16'd0, 16'd65535, 16'd30000, 9'd511, 5'd12);
            default: begin
               mn = $urandom_range(4000, 0);
               apply_config(16'(mn),
                            16'((mn + $urandom_range(8000, 0) > 65535) ?
                                65535 : mn + $urandom_range(8000, 0)),
                            16'($urandom_range(12000, 0)),
                            9'($urandom_range(300, 0)),
                            5'(($urandom_range(3, 0) == 0) ? $urandom_range(31, 0) :
                                                             $urandom_range(16, 1)));
            end
         endcase
         // Leave one phase in four at full rate on both sides.
         pace_bursty = (ph % 4 != 3);
         count = $urandom_range(70, 45);
         for (k = 0; k < count; k++)
            queue_reading(random_reading());
         wait_idle();
      end

      repeat (80) @(posedge clock);
      if (expected_votes.size() != 0) begin
         $error("%0d expected responses never arrived", expected_votes.size());
         failures++;
      end
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Request driver: offer queued readings in bursts, hold each one until it
   // is taken, and predict the response at the accepting edge.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         offer_next = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            expected_votes = {expected_votes,
                              predict_vote(reading(req_bus.reading_range,
                                                   req_bus.sensor_min_range,
                                                   req_bus.sensor_max_range,
                                                   req_bus.view_angle))};
            offer_next = 1'b0;
         end
         if (!offer_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_readings.size() > 0) begin
               next_reading = pending_readings.pop_front();
               req_bus.reading_range    <= next_reading.reading_range;
               req_bus.sensor_min_range <= next_reading.sensor_min_range;
               req_bus.sensor_max_range <= next_reading.sensor_max_range;
               req_bus.view_angle       <= next_reading.view_angle;
               offer_next = 1'b1;
               // End of a burst: pause for a while, then start a new one.
               if (pace_bursty) begin
                  if (burst_left == 0) begin
                     gap_left   = $urandom_range(15, 1);
                     burst_left = $urandom_range(10, 1);
                  end else begin
                     burst_left--;
                  end
               end
            end
         end
         req_bus.valid <= offer_next;
      end
   end

   // Response monitor: check each response against the oldest prediction and
   // drive ready from a rotating stall pattern, with two long hold-offs that
   // back the block up into its request channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            votes_seen++;
            if (expected_votes.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               want = expected_votes.pop_front();
               if (rsp_bus.obstacle_present !== want.obstacle_present) begin
                  $error("obstacle_present: expected %0d, got %0d",
                         want.obstacle_present, rsp_bus.obstacle_present);
                  failures++;
               end
               if (rsp_bus.obstacle_range !== want.obstacle_range) begin
                  $error("obstacle_range: expected %0d, got %0d",
                         want.obstacle_range, rsp_bus.obstacle_range);
                  failures++;
               end
               if (rsp_bus.danger_level !== want.danger_level) begin
                  $error("danger_level: expected %0d, got %0d",
                         want.danger_level, rsp_bus.danger_level);
                  failures++;
               end
               if (rsp_bus.latest_view_angle !== want.latest_view_angle) begin
                  $error("latest_view_angle: expected %0d, got %0d",
                         want.latest_view_angle, rsp_bus.latest_view_angle);
                  failures++;
               end
            end
            if (votes_seen == 150 || votes_seen == 480)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (!pace_bursty) begin
            ready_next = 1'b1;
         end else begin
            ready_next = stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            pattern_step++;
            // Reload now and then: mostly light stalls, sometimes heavy ones.
            if (pattern_step == 16) begin
               pattern_step = 0;
               stall_pattern = ($urandom_range(3, 0) == 0) ? 16'($urandom & $urandom) :
                                                             16'($urandom | $urandom);
            end
         end
         rsp_bus.ready <= ready_next;
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
